[hdl/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the pc sample trace buffer
// ----------------------------------------------------------------------------
package pst_pkg;

    // fixed field widths
    localparam int PC_W     = 32;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 14;
    localparam int KIND_W   = 1;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 32;

    // stream packing
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 48;   // read_data + fill_level, padded to bytes
    localparam int M_TUSER_W = STATUS_W;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_READ   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_RECORDED   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_WORD_READ  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY_RST  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_LAST_READ  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_LOGGING_ENABLE = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_WINDOW_LOW     = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_WINDOW_HIGH    = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;        // take the offered item this cycle
        logic finish_read;   // memory word is ready, publish the result
    } pst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_mem;      // offered item is a read that hits a stored word
        logic out_valid;     // output register holds an untaken result
    } pst_stat_t;

endpackage

[hdl/pst_ctrl.sv]
// ----------------------------------------------------------------------------
// pst_ctrl
// Item sequencing for the trace buffer: accept, then for a read of a stored word wait for the memory read
// ----------------------------------------------------------------------------
module pst_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               m_tready,
    input  pst_pkg::pst_stat_t stat,
    output pst_pkg::pst_cmd_t  cmd
);
    import pst_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RDATA
    } state_t;

    state_t state_reg;
    state_t state_next;

    // ready when idle and the output slot is free or being drained
    assign s_tready = (state_reg == ST_IDLE) && (!stat.out_valid || m_tready);

    always_comb begin
        cmd.accept      = s_tvalid && s_tready;
        cmd.finish_read = (state_reg == ST_RDATA);
        state_next      = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && stat.need_mem) begin
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/pst_datapath.sv]
// ----------------------------------------------------------------------------
// pst_datapath
// Sample store, indices, window compare, config and output register
// ----------------------------------------------------------------------------
module pst_datapath #(
    parameter int DEPTH = 8192
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [pst_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [pst_pkg::CFG_D_W-1:0]   cfg_wdata,
    input  logic [pst_pkg::KIND_W-1:0]    in_kind,
    input  logic [pst_pkg::PC_W-1:0]      in_pc,
    input  logic                          m_tready,
    output logic [pst_pkg::STATUS_W-1:0]  out_status,
    output logic [pst_pkg::PC_W-1:0]      out_data,
    output logic [pst_pkg::FILL_W-1:0]    out_fill,
    output logic                          out_valid,
    input  pst_pkg::pst_cmd_t             cmd,
    output pst_pkg::pst_stat_t            stat
);
    import pst_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW = AW + 1;
    localparam logic [WW-1:0] WR_FULL  = WW'(DEPTH);
    localparam logic [AW-1:0] RD_LAST  = AW'(DEPTH - 1);

    // config registers
    logic              log_en_reg;
    logic [PC_W-1:0]   win_lo_reg;
    logic [PC_W-1:0]   win_hi_reg;

    // indices
    logic [WW-1:0]     wr_idx_reg, wr_idx_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;

    // sample store
    logic [PC_W-1:0]   mem [DEPTH];
    logic [PC_W-1:0]   mem_rdata_reg;
    logic              mem_we;
    logic              mem_re;

    // output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg, status_next;
    logic [PC_W-1:0]       out_data_reg;
    logic [FILL_W-1:0]     out_fill_reg;
    logic [WW-1:0]         diff;

    logic full, in_win, empty, is_read;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_en_reg <= 1'b0;
            win_lo_reg <= '0;
            win_hi_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LOGGING_ENABLE: log_en_reg <= cfg_wdata[0];
                CFG_WINDOW_LOW:     win_lo_reg <= cfg_wdata;
                CFG_WINDOW_HIGH:    win_hi_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        is_read     = (in_kind == KIND_READ);
        full        = (wr_idx_reg >= WR_FULL);
        in_win      = (in_pc >= win_lo_reg) && (in_pc <= win_hi_reg);
        empty       = ({1'b0, rd_idx_reg} >= wr_idx_reg);
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (is_read) begin
            if (empty) begin
                status_next = STAT_EMPTY_RST;
                wr_idx_next = '0;
                rd_idx_next = '0;
            end else begin
                mem_re = cmd.accept;
                if (rd_idx_reg == RD_LAST) begin
                    status_next = STAT_LAST_READ;
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                end else begin
                    status_next = STAT_WORD_READ;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
        end else begin
            if (!log_en_reg || full) begin
                status_next = STAT_DROPPED;
            end else if (!in_win) begin
                status_next = STAT_OUTSIDE;
            end else begin
                status_next = STAT_RECORDED;
                mem_we      = cmd.accept;
                wr_idx_next = wr_idx_reg + 1'b1;
            end
        end
        diff          = wr_idx_next - {1'b0, rd_idx_next};
        stat.need_mem = is_read && !empty;
        stat.out_valid = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx_reg[AW-1:0]] <= in_pc;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                wr_idx_reg    <= wr_idx_next;
                rd_idx_reg    <= rd_idx_next;
                out_valid_reg <= !stat.need_mem;
            end else if (cmd.finish_read) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            out_status_reg <= status_next;
            out_data_reg   <= '0;
            out_fill_reg   <= FILL_W'(diff);
        end else if (cmd.finish_read) begin
            out_data_reg   <= mem_rdata_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_fill   = out_fill_reg;
    assign out_valid  = out_valid_reg;

endmodule

[hdl/pc_sample_trace_buffer.sv]
// ----------------------------------------------------------------------------
// pc_sample_trace_buffer
// Program-counter trace buffer with an inclusive address window filter
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                              tuser
//  --------  ---  ---------------------------------  ------------
//  s_ (item) in   [31:0] pc_value                    [0] kind
//  m_ (res)  out  [31:0] read_data, [45:32] fill     [2:0] status
//  cfg_      in   write port: cfg_we, cfg_addr, cfg_wdata (no read-back)
//
//  a sample item is handled in ST_IDLE; a read item that returns a stored word
//  also passes through ST_RDATA, the registered read of the sample store
//  one item is in flight at a time; the output register lets the next item
//  be accepted in the same cycle the pending result is taken
//  aresetn is synchronous, active low; it clears indices, config and the
//  output valid flag; the sample store itself is not cleared
//  a stalled result (m_tready low) holds the block off the input side
//
module pc_sample_trace_buffer #(
    parameter int DEPTH = 8192
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration write port
    input  logic                            cfg_we,
    input  logic [pst_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [pst_pkg::CFG_D_W-1:0]     cfg_wdata,

    // item input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pst_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] pc_value
    input  logic [pst_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] kind

    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pst_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] read_data, [45:32] fill_level
    output logic [pst_pkg::M_TUSER_W-1:0]   m_tuser    // [2:0] status
);
    import pst_pkg::*;

    pst_cmd_t              cmd;
    pst_stat_t             stat;
    logic [STATUS_W-1:0]   res_status;
    logic [PC_W-1:0]       res_data;
    logic [FILL_W-1:0]     res_fill;

    // sequencing: accept, optional memory read state
    pst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, indices, window test, result register
    pst_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_kind    (s_tuser[KIND_W-1:0]),
        .in_pc      (s_tdata[PC_W-1:0]),
        .m_tready   (m_tready),
        .out_status (res_status),
        .out_data   (res_data),
        .out_fill   (res_fill),
        .out_valid  (m_tvalid),
        .cmd        (cmd),
        .stat       (stat)
    );

    // pack result fields, zero pad to whole bytes
    assign m_tdata = {{(M_TDATA_W - PC_W - FILL_W){1'b0}}, res_fill, res_data};
    assign m_tuser = res_status;

endmodule
